/* hdl/lhe_pkg.sv */
package lhe_pkg;
   localparam int LOG_FRAC = 24;
   localparam int LOG_INT_BITS = 6;
   localparam int LOG_BITS = LOG_INT_BITS + LOG_FRAC;
   localparam int SUM_BITS = 64;
   localparam int ENT_BITS = 20;
   localparam int OUT_COUNT_BITS = 20;
   localparam int LEN_BITS = 10;
   localparam int BOUND_OUT_BITS = 8;
endpackage

/* hdl/lhe_log2.sv */
// Iterative log2 in Q.24: priority search over the operand bits, then one squaring per
// fraction bit. The 32x32 square is split into two 32x16 partial products, the low one registered.
module lhe_log2 (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] x,
   output logic        busy,
   output logic        done,
   output logic [lhe_pkg::LOG_BITS-1:0] result
);
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_NORM = 3'd1;
   localparam logic [2:0] S_MLO  = 3'd2;
   localparam logic [2:0] S_MHI  = 3'd3;
   localparam logic [2:0] S_DONE = 3'd4;

   logic [2:0]  state_ff, state_in;
   logic [31:0] m_ff, m_in;
   logic [4:0]  n_ff, n_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [lhe_pkg::LOG_FRAC-1:0] frac_ff, frac_in;
   logic [47:0] plo_ff, plo_in;
   logic [47:0] phi;
   logic [63:0] sq;
   logic [32:0] mnew;

   assign phi  = 48'(m_ff) * 48'(m_ff[31:16]);
   assign sq   = 64'(plo_ff) + (64'(phi) << 16);
   assign mnew = sq[63:31];

   always_comb begin
      state_in = state_ff;
      m_in = m_ff;
      n_in = n_ff;
      cnt_in = cnt_ff;
      frac_in = frac_ff;
      plo_in = plo_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               m_in = x;
               n_in = 5'd31;
               state_in = S_NORM;
            end
         end
         S_NORM: begin
            // one bit per cycle; at most 31 steps
            if (m_ff[31] || n_ff == 5'd0) begin
               cnt_in = 5'd0;
               frac_in = '0;
               state_in = S_MLO;
            end else begin
               m_in = {m_ff[30:0], 1'b0};
               n_in = n_ff - 5'd1;
            end
         end
         S_MLO: begin
            plo_in = 48'(m_ff) * 48'(m_ff[15:0]);
            state_in = S_MHI;
         end
         S_MHI: begin
            frac_in = {frac_ff[lhe_pkg::LOG_FRAC-2:0], mnew[32]};
            m_in = mnew[32] ? mnew[32:1] : mnew[31:0];
            cnt_in = cnt_ff + 5'd1;
            state_in = (cnt_ff == 5'(lhe_pkg::LOG_FRAC - 1)) ? S_DONE : S_MLO;
         end
         S_DONE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
      m_ff <= m_in;
      n_ff <= n_in;
      cnt_ff <= cnt_in;
      frac_ff <= frac_in;
      plo_ff <= plo_in;
   end

   assign busy = state_ff != S_IDLE;
   assign done = state_ff == S_DONE;
   assign result = {1'b0, n_ff, frac_ff};
endmodule

/* hdl/lhe_div.sv */
// Restoring divider, one quotient bit per cycle, 64 by 32 bits.
module lhe_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [63:0] quotient
);
   logic        run_ff;
   logic        done_ff;
   logic [6:0]  cnt_ff;
   logic [63:0] q_ff;
   logic [32:0] r_ff;
   logic [32:0] shifted;
   logic        fits;

   assign shifted = {r_ff[31:0], q_ff[63]};
   assign fits = shifted >= {1'b0, divisor};

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start && !run_ff) begin
            run_ff <= 1'b1;
         end else if (run_ff && cnt_ff == 7'd63) begin
            run_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
      if (start && !run_ff) begin
         q_ff <= dividend;
         r_ff <= '0;
         cnt_ff <= '0;
      end else if (run_ff) begin
         r_ff <= fits ? shifted - {1'b0, divisor} : shifted;
         q_ff <= {q_ff[62:0], fits};
         cnt_ff <= cnt_ff + 7'd1;
      end
   end

   assign done = done_ff;
   assign quotient = q_ff;
endmodule

/* hdl/length_histogram_entropy.sv */
// Length histogram with base-2 Shannon entropy. Each length beat is one read-modify-write
// of a bin in a synchronous RAM: the read is issued in S_IDLE and the write back follows
// in S_UPD, and no new length is taken before the write back. The last-marked beat also
// starts the entropy walk: each bin from min to max is read, logged by a shared iterative
// log2 unit when its count is nonzero, multiplied into a 64-bit sum, and the bin is
// cleared in the same pass. Then log2(total) and a 64-step divide finish the result.
// The result sits in its own output registers: a beat waiting on the receiver does not
// hold off new lengths, but once the next result is ready the block waits in S_OUT and
// takes no lengths until the beat is gone. After reset a clearing pass writes zero to
// every bin before the first beat is taken; afterwards the walk keeps every bin outside
// the touched range at zero.
module length_histogram_entropy #(
   parameter int BIN_COUNT = 256,
   parameter int COUNT_BITS = 20
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [lhe_pkg::LEN_BITS-1:0] req_length,
   input  logic        req_last_item,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [lhe_pkg::ENT_BITS-1:0]       rsp_entropy_q16,
   output logic [lhe_pkg::OUT_COUNT_BITS-1:0] rsp_sample_count,
   output logic [lhe_pkg::BOUND_OUT_BITS-1:0] rsp_min_length,
   output logic [lhe_pkg::BOUND_OUT_BITS-1:0] rsp_max_length
);
   localparam int IDX_BITS = $clog2(BIN_COUNT);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [IDX_BITS-1:0] TOP_IDX = IDX_BITS'(BIN_COUNT - 1);

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_UPD   = 4'd2;
   localparam logic [3:0] S_WRD   = 4'd3;  // walk: read issued
   localparam logic [3:0] S_WCHK  = 4'd4;  // walk: data back
   localparam logic [3:0] S_WLOG  = 4'd5;
   localparam logic [3:0] S_WMUL  = 4'd6;
   localparam logic [3:0] S_TLOG  = 4'd7;
   localparam logic [3:0] S_TWAIT = 4'd8;
   localparam logic [3:0] S_DIV   = 4'd9;
   localparam logic [3:0] S_DWAIT = 4'd10;
   localparam logic [3:0] S_OUT   = 4'd11;

   // bin store
   logic [COUNT_BITS-1:0] mem [BIN_COUNT];
   logic [COUNT_BITS-1:0] rd_data_ff;
   logic                  we;
   logic [IDX_BITS-1:0]   waddr, raddr;
   logic [COUNT_BITS-1:0] wdata;

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rd_data_ff <= mem[raddr];
   end

   logic [3:0]            state_ff;
   logic [IDX_BITS-1:0]   idx_ff;
   logic [COUNT_BITS-1:0] total_ff;
   logic [IDX_BITS-1:0]   low_ff, high_ff;
   logic                  last_ff;
   logic [63:0]           sum_ff;
   logic [COUNT_BITS-1:0] h_ff;
   logic [lhe_pkg::LOG_BITS-1:0] lt_ff;
   logic [lhe_pkg::ENT_BITS-1:0] ent_ff;
   logic [lhe_pkg::OUT_COUNT_BITS-1:0] cnt_out_ff;
   logic [lhe_pkg::BOUND_OUT_BITS-1:0] min_out_ff, max_out_ff;

   logic        log_start, log_busy, log_done;
   logic [31:0] log_x;
   logic [lhe_pkg::LOG_BITS-1:0] log_res;
   logic        div_start, div_done;
   logic [63:0] quot;

   logic req_fire;
   logic in_range;
   logic out_load;
   logic [IDX_BITS-1:0] len_idx;

   assign req_ready = state_ff == S_IDLE;
   assign req_fire = req_valid && req_ready;
   assign len_idx = IDX_BITS'(req_length);
   assign in_range = ({22'd0, req_length} < 32'(BIN_COUNT)) && total_ff != COUNT_MAX;
   // output registers free: the previous beat is gone or leaves this cycle
   assign out_load = state_ff == S_OUT && (!rsp_valid || rsp_ready);

   assign log_x = (state_ff == S_TLOG) ? 32'(total_ff) : 32'(h_ff);
   assign log_start = state_ff == S_WLOG && !log_busy && !log_done
                    || state_ff == S_TLOG;
   assign div_start = state_ff == S_DIV;

   lhe_log2 u_log (
      .clock(clock), .reset(reset), .start(log_start), .x(log_x),
      .busy(log_busy), .done(log_done), .result(log_res)
   );

   lhe_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(sum_ff),
      .divisor(32'(total_ff)), .done(div_done), .quotient(quot)
   );

   // memory port control
   always_comb begin
      we = 1'b0;
      waddr = idx_ff;
      wdata = '0;
      raddr = idx_ff;
      case (state_ff)
         S_CLEAR: we = 1'b1;
         S_IDLE:  raddr = len_idx;
         S_UPD: begin
            we = 1'b1;
            wdata = rd_data_ff + COUNT_BITS'(1);
         end
         S_WCHK: we = 1'b1;  // clear the bin as it is read
         default: ;
      endcase
   end

   // quotient and log2(total) hold after the divide, so rounding is done at load
   logic [63:0] e_full;
   logic [63:0] lt_w;
   logic [63:0] e_round;
   logic [lhe_pkg::ENT_BITS-1:0] ent_sat;
   assign lt_w = 64'(lt_ff);
   assign e_full = (quot >= lt_w) ? 64'd0 : lt_w - quot;
   assign e_round = (e_full + 64'd128) >> 8;
   assign ent_sat = (e_round > 64'hFFFFF) ? 20'hFFFFF : 20'(e_round);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         idx_ff <= '0;
         total_ff <= '0;
         low_ff <= TOP_IDX;
         high_ff <= '0;
         rsp_valid <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready && !out_load) rsp_valid <= 1'b0;
         case (state_ff)
            S_CLEAR: begin
               idx_ff <= idx_ff + IDX_BITS'(1);
               if (idx_ff == TOP_IDX) state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (req_fire) begin
                  last_ff <= req_last_item;
                  idx_ff <= len_idx;
                  if (in_range) begin
                     state_ff <= S_UPD;
                     total_ff <= total_ff + COUNT_BITS'(1);
                     if (len_idx > high_ff) high_ff <= len_idx;
                     if (len_idx < low_ff) low_ff <= len_idx;
                  end else if (req_last_item) begin
                     state_ff <= S_WRD;
                     idx_ff <= low_ff;
                     sum_ff <= '0;
                  end
               end
            end
            S_UPD: begin
               if (last_ff) begin
                  state_ff <= S_WRD;
                  idx_ff <= low_ff;
                  sum_ff <= '0;
               end else state_ff <= S_IDLE;
            end
            S_WRD: state_ff <= (total_ff == '0) ? S_OUT : S_WCHK;
            S_WCHK: begin
               h_ff <= rd_data_ff;
               if (rd_data_ff != '0) state_ff <= S_WLOG;
               else if (idx_ff >= high_ff) state_ff <= S_TLOG;
               else begin
                  idx_ff <= idx_ff + IDX_BITS'(1);
                  state_ff <= S_WRD;
               end
            end
            S_WLOG: if (log_done) state_ff <= S_WMUL;
            S_WMUL: begin
               sum_ff <= sum_ff + 64'(h_ff) * 64'(log_res);
               if (idx_ff >= high_ff) state_ff <= S_TLOG;
               else begin
                  idx_ff <= idx_ff + IDX_BITS'(1);
                  state_ff <= S_WRD;
               end
            end
            S_TLOG: state_ff <= S_TWAIT;
            S_TWAIT: if (log_done) begin
               lt_ff <= log_res;
               state_ff <= S_DIV;
            end
            S_DIV: state_ff <= S_DWAIT;
            S_DWAIT: if (div_done) state_ff <= S_OUT;
            S_OUT: if (out_load) begin
               ent_ff <= (total_ff == '0) ? '0 : ent_sat;
               cnt_out_ff <= (32'(total_ff) > 32'hFFFFF) ? 20'hFFFFF : 20'(total_ff);
               min_out_ff <= (32'(low_ff) > 32'd255) ? 8'd255 : 8'(low_ff);
               max_out_ff <= (32'(high_ff) > 32'd255) ? 8'd255 : 8'(high_ff);
               rsp_valid <= 1'b1;
               total_ff <= '0;
               low_ff <= TOP_IDX;
               high_ff <= '0;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_entropy_q16 = ent_ff;
   assign rsp_sample_count = cnt_out_ff;
   assign rsp_min_length = min_out_ff;
   assign rsp_max_length = max_out_ff;

   // the walk never runs past the recorded maximum
   a_walk_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WCHK) |-> (idx_ff <= high_ff))
      else $error("walk index beyond max");
   // a waiting result beat holds valid and payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable({rsp_entropy_q16,
      rsp_sample_count, rsp_min_length, rsp_max_length})))
      else $error("result beat changed while waiting");
   // the update write comes in the cycle after its read
   a_upd_follow: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UPD) |-> $past(state_ff == S_IDLE))
      else $error("update without read");
endmodule
